[rtl/core/u8dec_pkg.sv]
// shared types and constants for the utf-8 sequence decoder
`default_nettype none

package u8dec_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned CP_W     = 25;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned SUM_W    = 27;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 32;

    // longest sequence handled
    localparam logic [LEN_W-1:0] MAX_LEN = 3'd5;

    // lead byte class masks and patterns
    localparam logic [BYTE_W-1:0] LEAD1_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD1_PAT  = 8'h00;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD5_PAT  = 8'hF8;

    // five-byte values must stay below this
    localparam logic [SUM_W-1:0] FIVE_LIMIT = 27'h100_0000;

    // error encoding, -1 in both fields
    localparam logic signed [CP_W-1:0]  CP_ERR  = '1;
    localparam logic signed [CNT_W-1:0] CNT_ERR = '1;

    // consumed byte counts
    localparam logic signed [CNT_W-1:0] CNT_ONE   = 4'sd1;
    localparam logic signed [CNT_W-1:0] CNT_TWO   = 4'sd2;
    localparam logic signed [CNT_W-1:0] CNT_THREE = 4'sd3;
    localparam logic signed [CNT_W-1:0] CNT_FOUR  = 4'sd4;
    localparam logic signed [CNT_W-1:0] CNT_FIVE  = 4'sd5;

    typedef struct packed {
        logic [LEN_W-1:0]  avail_len;
        logic [BYTE_W-1:0] byte4;
        logic [BYTE_W-1:0] byte3;
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte0;
    } t_item;

    typedef struct packed {
        logic signed [CNT_W-1:0] consumed;
        logic signed [CP_W-1:0]  code_point;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/u8dec_decode.sv]
// combinational decode of one byte window into a code point and length
`default_nettype none

module u8dec_decode (
    input  u8dec_pkg::t_item   i_item,
    output u8dec_pkg::t_result o_result
);
    import u8dec_pkg::*;

    logic [LEN_W-1:0] len;
    logic             c1, c2, c3, c4;
    logic [SUM_W-1:0] v2, v3, v4, v5;

    assign len = (i_item.avail_len > MAX_LEN) ? MAX_LEN : i_item.avail_len;

    // only bit 7 of a continuation byte is checked
    assign c1 = i_item.byte1[7];
    assign c2 = i_item.byte2[7];
    assign c3 = i_item.byte3[7];
    assign c4 = i_item.byte4[7];

    // parts are added, overlapping fields carry into each other
    assign v2 = (SUM_W'(i_item.byte0[4:0]) << 6) + SUM_W'(i_item.byte1[6:0]);
    assign v3 = (SUM_W'(i_item.byte0[3:0]) << 12) + (SUM_W'(i_item.byte1[6:0]) << 6)
              + SUM_W'(i_item.byte2[6:0]);
    assign v4 = (SUM_W'(i_item.byte0[2:0]) << 18) + (SUM_W'(i_item.byte1[6:0]) << 12)
              + (SUM_W'(i_item.byte2[6:0]) << 6) + SUM_W'(i_item.byte3[6:0]);
    assign v5 = (SUM_W'(i_item.byte0[2:0]) << 24) + (SUM_W'(i_item.byte1[6:0]) << 18)
              + (SUM_W'(i_item.byte2[6:0]) << 12) + (SUM_W'(i_item.byte3[6:0]) << 6)
              + SUM_W'(i_item.byte4[6:0]);

    always_comb begin
        o_result.code_point = CP_ERR;
        o_result.consumed   = CNT_ERR;
        if ((i_item.byte0 & LEAD1_MASK) == LEAD1_PAT) begin
            if (len >= 3'd1) begin
                o_result.code_point = CP_W'(i_item.byte0);
                o_result.consumed   = CNT_ONE;
            end
        end else if ((i_item.byte0 & LEAD2_MASK) == LEAD2_PAT) begin
            if (len >= 3'd2 && c1) begin
                o_result.code_point = v2[CP_W-1:0];
                o_result.consumed   = CNT_TWO;
            end
        end else if ((i_item.byte0 & LEAD3_MASK) == LEAD3_PAT) begin
            if (len >= 3'd3 && c1 && c2) begin
                o_result.code_point = v3[CP_W-1:0];
                o_result.consumed   = CNT_THREE;
            end
        end else if ((i_item.byte0 & LEAD4_MASK) == LEAD4_PAT) begin
            if (len >= 3'd4 && c1 && c2 && c3) begin
                o_result.code_point = v4[CP_W-1:0];
                o_result.consumed   = CNT_FOUR;
            end
        end else if ((i_item.byte0 & LEAD5_MASK) == LEAD5_PAT) begin
            if (len >= 3'd5 && c1 && c2 && c3 && c4 && (v5 < FIVE_LIMIT)) begin
                o_result.code_point = v5[CP_W-1:0];
                o_result.consumed   = CNT_FIVE;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/utf8_sequence_decoder_unit.sv]
// an input transaction passes through the input register and then the result register before its result is valid
// throughput: one sequence per cycle, sustained while the output side is ready
// the input register and the result register are each one pipeline stage
// reset (synchronous, active low) clears both stage valid flags; data is not reset
// a stall at the output reaches the input ready in the same cycle through the ready chain
`default_nettype none

module utf8_sequence_decoder_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // slave side
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24], byte4 [39:32],
    // avail_len [42:40], zero fill [47:43]
    input  wire  [u8dec_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // master side
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // code_point [24:0], consumed [28:25], zero fill [31:29]
    output logic [u8dec_pkg::M_DATA_W-1:0]   o_m_axis_tdata
);
    import u8dec_pkg::*;

    // stage 1: input register
    logic    r_in_valid;
    t_item   r_in;
    // stage 2: result register
    logic    r_out_valid;
    t_result r_out;

    logic    out_ready;   // result stage can take a new value
    logic    in_ready;    // input stage can take a new transaction
    t_result dec_result;

    assign out_ready = !r_out_valid || i_m_axis_tready;
    assign in_ready  = !r_in_valid || out_ready;

    u8dec_decode u_decode (
        .i_item   (r_in),
        .o_result (dec_result)
    );

    // input stage: capture on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in <= i_s_axis_tdata[$bits(t_item)-1:0];
        end
    end

    // result stage: decoded value of the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_out <= dec_result;
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_DATA_W - $bits(t_result))'(0), r_out};

    // error flags in both fields always agree
    a_err_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.consumed == CNT_ERR) == (r_out.code_point == CP_ERR)))
        else $error("code point and consumed disagree on error");

    // a good result consumes one to five bytes
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.consumed != CNT_ERR)
            |-> (r_out.consumed >= CNT_ONE && r_out.consumed <= CNT_FIVE))
        else $error("consumed count out of range");

    // an item in the input stage moves on when the result stage is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_ready) |=> r_out_valid)
        else $error("item lost between stages");

    // input stalls only when both stages hold items
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for the utf-8 sequence decoder unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import u8dec_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned TABLE_ROWS   = 25;

    // one row of the directed table; exp is only used when typed is set
    typedef struct {
        t_item   item;
        bit      typed;
        t_result exp;
    } t_stim_row;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24], byte4 [39:32],
    // avail_len [42:40], zero fill [47:43]
    logic [S_DATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // code_point [24:0], consumed [28:25], zero fill [31:29]
    logic [M_DATA_W-1:0]   o_m_axis_tdata;

    // results of items on the bus but not yet taken, and of items taken
    t_result     presented_results [$];
    t_result     expected_results [$];
    t_stim_row   dir_table [TABLE_ROWS];

    // no idling on either side while set
    logic        steady = 1'b0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned checked_count  = 0;
    int unsigned rejected_count = 0;
    int unsigned length_count [1:5] = '{default: 0};
    t_result     got_result;
    t_result     want_result;
    t_item       rand_item;

    utf8_sequence_decoder_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // decodes one byte window the way the block should
    function automatic t_result decode_sequence(t_item it);
        t_result          r;
        logic [31:0]      sum;
        logic [LEN_W-1:0] len;
        bit               ok;
        len = (it.avail_len > MAX_LEN) ? MAX_LEN : it.avail_len;
        ok  = 1'b0;
        sum = '0;
        r.consumed = CNT_ERR;
        if ((it.byte0 & LEAD1_MASK) == LEAD1_PAT) begin
            if (len >= 1) begin
                sum = 32'(it.byte0);
                r.consumed = CNT_ONE;
                ok = 1'b1;
            end
        end else if ((it.byte0 & LEAD2_MASK) == LEAD2_PAT) begin
            if (len >= 2 && it.byte1[7]) begin
                sum = (32'(it.byte0[4:0]) << 6) + 32'(it.byte1[6:0]);
                r.consumed = CNT_TWO;
                ok = 1'b1;
            end
        end else if ((it.byte0 & LEAD3_MASK) == LEAD3_PAT) begin
            if (len >= 3 && it.byte1[7] && it.byte2[7]) begin
                sum = (32'(it.byte0[3:0]) << 12) + (32'(it.byte1[6:0]) << 6)
                    + 32'(it.byte2[6:0]);
                r.consumed = CNT_THREE;
                ok = 1'b1;
            end
        end else if ((it.byte0 & LEAD4_MASK) == LEAD4_PAT) begin
            if (len >= 4 && it.byte1[7] && it.byte2[7] && it.byte3[7]) begin
                sum = (32'(it.byte0[2:0]) << 18) + (32'(it.byte1[6:0]) << 12)
                    + (32'(it.byte2[6:0]) << 6) + 32'(it.byte3[6:0]);
                r.consumed = CNT_FOUR;
                ok = 1'b1;
            end
        end else if ((it.byte0 & LEAD5_MASK) == LEAD5_PAT) begin
            // parts are added, so the limit check sees the full sum
            sum = (32'(it.byte0[2:0]) << 24) + (32'(it.byte1[6:0]) << 18)
                + (32'(it.byte2[6:0]) << 12) + (32'(it.byte3[6:0]) << 6)
                + 32'(it.byte4[6:0]);
            if (len >= 5 && it.byte1[7] && it.byte2[7] && it.byte3[7]
                && it.byte4[7] && sum < 32'(FIVE_LIMIT)) begin
                r.consumed = CNT_FIVE;
                ok = 1'b1;
            end
        end
        if (ok) begin
            r.code_point = sum[CP_W-1:0];
        end else begin
            r.code_point = CP_ERR;
            r.consumed   = CNT_ERR;
        end
        return r;
    endfunction

    function automatic t_stim_row row(logic [LEN_W-1:0] len, logic [7:0] b0, logic [7:0] b1,
                                      logic [7:0] b2, logic [7:0] b3, logic [7:0] b4,
                                      bit typed, int cp, int cnt);
        t_stim_row r;
        r.item = '{avail_len: len, byte4: b4, byte3: b3, byte2: b2, byte1: b1, byte0: b0};
        r.typed = typed;
        r.exp.code_point = cp[CP_W-1:0];
        r.exp.consumed   = cnt[CNT_W-1:0];
        return r;
    endfunction

    // mostly well-formed sequences with random payload, some broken, some noise
    function automatic t_item random_sequence();
        t_item       it;
        int unsigned n;
        int unsigned pick;
        int unsigned k;
        it.byte0     = 8'($urandom);
        it.byte1     = 8'($urandom);
        it.byte2     = 8'($urandom);
        it.byte3     = 8'($urandom);
        it.byte4     = 8'($urandom);
        it.avail_len = 3'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return it;
        end
        n = $urandom_range(1, 5);
        case (n)
            1: it.byte0 = {1'b0, 7'($urandom)};
            2: it.byte0 = {3'b110, 5'($urandom)};
            3: it.byte0 = {4'b1110, 4'($urandom)};
            4: it.byte0 = {5'b11110, 3'($urandom)};
            default: begin
                // only the lowest five-byte lead can stay below the limit
                it.byte0 = $urandom_range(0, 1) ? 8'hF8 : {6'b111110, 2'($urandom)};
            end
        endcase
        if (n > 1) it.byte1[7] = 1'b1;
        if (n > 2) it.byte2[7] = 1'b1;
        if (n > 3) it.byte3[7] = 1'b1;
        if (n > 4) it.byte4[7] = 1'b1;
        it.avail_len = 3'($urandom_range(n, 7));
        if (pick < 30) begin
            case ($urandom_range(0, 2))
                0: it.avail_len = 3'($urandom_range(0, n - 1));
                1: begin
                    // knock bit 7 off one continuation byte, or turn a one-byte lead into a stray continuation
                    k = (n > 1) ? $urandom_range(1, n - 1) : 0;
                    case (k)
                        1: it.byte1[7] = 1'b0;
                        2: it.byte2[7] = 1'b0;
                        3: it.byte3[7] = 1'b0;
                        4: it.byte4[7] = 1'b0;
                        default: it.byte0 = {2'b10, 6'($urandom)};
                    endcase
                end
                default: begin
                    // stray continuation or six-byte and longer lead
                    it.byte0 = $urandom_range(0, 1) ? {2'b10, 6'($urandom)}
                                                    : {6'b111111, 2'($urandom)};
                end
            endcase
        end
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // puts one transaction on the slave side and holds it until taken
    task automatic send_transaction(t_item it, t_result want);
        while (!steady && $urandom_range(0, 99) < 30) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        presented_results.push_back(want);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_DATA_W'(it);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // holds off the sender until every result has come back
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0 || presented_results.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // master side backpressure, off during the steady stretch
    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 30);
    end

    // result check first, then record the transaction taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_result = t_result'(o_m_axis_tdata[CP_W+CNT_W-1:0]);
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected",
                                              o_m_axis_tdata));
                end else begin
                    want_result = expected_results.pop_front();
                    checked_count++;
                    if (want_result.consumed == CNT_ERR) begin
                        rejected_count++;
                    end else begin
                        length_count[want_result.consumed]++;
                    end
                    if (got_result.code_point !== want_result.code_point) begin
                        report_mismatch($sformatf("code_point got %0d want %0d",
                                                  got_result.code_point,
                                                  want_result.code_point));
                    end
                    if (got_result.consumed !== want_result.consumed) begin
                        report_mismatch($sformatf("consumed got %0d want %0d",
                                                  got_result.consumed,
                                                  want_result.consumed));
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(presented_results.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        dir_table = '{
            // one-byte extremes and a lead with nothing available
            row(3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 0,          1),
            row(3'd1, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 127,        1),
            row(3'd0, 8'h41, 8'h80, 8'h80, 8'h80, 8'h80, 1'b1, -1,        -1),
            // stray continuation leads
            row(3'd5, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 1'b1, -1,        -1),
            row(3'd5, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 1'b1, -1,        -1),
            // two-byte forms
            row(3'd2, 8'hC2, 8'hA9, 8'h00, 8'h00, 8'h00, 1'b0, 0,          0),
            row(3'd2, 8'hDF, 8'hBF, 8'h00, 8'h00, 8'h00, 1'b1, 'h7FF,      2),
            row(3'd2, 8'hC0, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1, 0,          2),
            row(3'd2, 8'hC3, 8'h3F, 8'h00, 8'h00, 8'h00, 1'b1, -1,        -1),
            row(3'd1, 8'hC3, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1, -1,        -1),
            // three-byte forms
            row(3'd3, 8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 1'b0, 0,          0),
            row(3'd3, 8'hEF, 8'hBF, 8'hBF, 8'h00, 8'h00, 1'b1, 'hFFFF,     3),
            row(3'd3, 8'hE0, 8'h80, 8'h7F, 8'h00, 8'h00, 1'b1, -1,        -1),
            // four-byte forms
            row(3'd4, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00, 1'b0, 0,          0),
            row(3'd4, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 1'b1, 'h1FFFFF,   4),
            row(3'd3, 8'hF4, 8'h80, 8'h80, 8'h80, 8'h00, 1'b1, -1,        -1),
            // five-byte forms around the limit
            row(3'd5, 8'hF8, 8'h80, 8'h80, 8'h80, 8'h80, 1'b1, 0,          5),
            row(3'd5, 8'hF8, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 1'b1, 'hFFFFFF,   5),
            row(3'd5, 8'hF9, 8'h80, 8'h80, 8'h80, 8'h80, 1'b1, -1,        -1),
            row(3'd7, 8'hFB, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, -1,        -1),
            row(3'd5, 8'hF8, 8'hBF, 8'hBF, 8'hBF, 8'h3F, 1'b1, -1,        -1),
            // six-byte and longer leads
            row(3'd5, 8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 1'b1, -1,        -1),
            row(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, -1,        -1),
            // saturated lengths, trailing bytes ignored
            row(3'd6, 8'h41, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 0,          0),
            row(3'd7, 8'hDF, 8'hBF, 8'h00, 8'hFF, 8'h00, 1'b0, 0,          0)
        };

        // synchronous reset held at the start
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_table[i]) begin
            send_transaction(dir_table[i].item,
                             dir_table[i].typed ? dir_table[i].exp
                                                : decode_sequence(dir_table[i].item));
        end
        wait_for_results();

        // random part, with a steady stretch and a full pause midway
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 250) begin
                wait_for_results();
            end
            steady <= (n >= 300 && n < 400);
            rand_item = random_sequence();
            send_transaction(rand_item, decode_sequence(rand_item));
        end
        steady <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results over all lead classes and lengths 0 to 7",
                 checked_count);
        $display("decoded by length 1..5: %0d %0d %0d %0d %0d, rejected: %0d",
                 length_count[1], length_count[2], length_count[3],
                 length_count[4], length_count[5], rejected_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
